// ----- rtl/clcd_pkg.sv -----
package clcd_pkg;

  // request kinds carried in the input tuser
  typedef enum logic [2:0] {
    KIND_CMD   = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_POS   = 3'd2,
    KIND_INIT  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_e;

  // configuration register indexes
  localparam logic [2:0] CFG_HIGH_WAIT  = 3'd0;
  localparam logic [2:0] CFG_LOW_WAIT   = 3'd1;
  localparam logic [2:0] CFG_POWER_WAIT = 3'd2;
  localparam logic [2:0] CFG_CLEAR_WAIT = 3'd3;

  localparam logic [15:0] HIGH_WAIT_RST  = 16'd1000;
  localparam logic [15:0] LOW_WAIT_RST   = 16'd3000;
  localparam logic [15:0] POWER_WAIT_RST = 16'd40000;
  localparam logic [15:0] CLEAR_WAIT_RST = 16'd3000;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] ADDR_COL_MSK = 8'h0F;
  localparam logic [2:0] INIT_LAST    = 3'd4;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // one byte to be sent as two nibble transfers
  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       pre_wait;   // carry the power-on wait on the high nibble
    logic       extra_wait; // add the clear wait after the low nibble
    logic       last;
  } op_t;

  typedef struct packed {
    logic [15:0] high_wait;
    logic [15:0] low_wait;
    logic [15:0] power_wait;
    logic [15:0] clear_wait;
  } cfg_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] pre_wait;
    logic [15:0] wait_after;
    logic        last;
  } xfer_t;

  function automatic logic [7:0] init_byte(input logic [2:0] step);
    logic [7:0] b;
    case (step)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h0C;
      3'd4:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] row_base(input logic [2:0] row);
    logic [7:0] b;
    case (row)
      3'd1:    b = 8'h80;
      3'd2:    b = 8'hC0;
      3'd3:    b = 8'h94;
      3'd4:    b = 8'hD4;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/clcd_front.sv -----
module clcd_front
  import clcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  logic [2:0] req_kind_i,
  input  logic [7:0] req_byte_i,
  input  logic [2:0] req_row_i,
  input  logic [7:0] req_column_i,
  output logic       push_o,
  output op_t        push_op_o,
  input  logic       full_i
);

  logic       pend_q, pend_d;
  kind_e      kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic [7:0] addr_q, addr_d;
  logic [2:0] step_q, step_d;
  logic       accept;
  logic       kind_ok;
  logic       row_ok;
  op_t        op;

  always_comb begin
    op = '0;
    case (kind_q)
      KIND_CMD: begin
        op.value = byte_q;
        op.last  = 1'b1;
      end
      KIND_DATA: begin
        op.rs    = 1'b1;
        op.value = byte_q;
        op.last  = 1'b1;
      end
      KIND_POS: begin
        if (step_q == 3'd0) begin
          op.value = addr_q;
        end else begin
          op.rs    = 1'b1;
          op.value = byte_q;
          op.last  = 1'b1;
        end
      end
      KIND_INIT: begin
        op.value    = init_byte(step_q);
        op.pre_wait = (step_q == 3'd0);
        op.last     = (step_q == INIT_LAST);
      end
      KIND_CLEAR: begin
        op.value      = CMD_CLEAR;
        op.extra_wait = 1'b1;
        op.last       = 1'b1;
      end
      default: op = '0;
    endcase
  end

  assign push_o      = pend_q && !full_i;
  assign push_op_o   = op;
  assign req_ready_o = !pend_q || (push_o && op.last);
  assign accept      = req_valid_i && req_ready_o;
  assign kind_ok     = (req_kind_i <= KIND_CLEAR);
  assign row_ok      = (req_row_i >= 3'd1) && (req_row_i <= 3'd4);

  always_comb begin
    pend_d = pend_q;
    kind_d = kind_q;
    byte_d = byte_q;
    addr_d = addr_q;
    step_d = step_q;
    if (accept) begin
      // unused kinds are taken and dropped
      pend_d = kind_ok;
      kind_d = kind_e'(req_kind_i);
      byte_d = req_byte_i;
      addr_d = row_base(req_row_i) | (req_column_i & ADDR_COL_MSK);
      step_d = (kind_e'(req_kind_i) == KIND_POS && !row_ok) ? 3'd1 : 3'd0;
    end else if (push_o) begin
      if (op.last) begin
        pend_d = 1'b0;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      kind_q <= KIND_CMD;
      step_q <= 3'd0;
    end else begin
      pend_q <= pend_d;
      kind_q <= kind_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    addr_q <= addr_d;
  end

endmodule

// ----- rtl/clcd_fifo.sv -----
module clcd_fifo
  import clcd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  head_op_o,
  output logic empty_o
);

  op_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;

  assign full_o    = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o   = (count_q == '0);
  assign head_op_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/clcd_back.sv -----
module clcd_back
  import clcd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  op_t   head_op_i,
  input  logic  empty_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output xfer_t out_o
);

  logic        valid_q, valid_d;
  logic        phase_q, phase_d;
  xfer_t       out_q, out_d;
  logic        load;
  logic [16:0] low_sum;
  logic [15:0] low_wait;

  // saturate the low-nibble wait at the top of the 16-bit range
  assign low_sum  = {1'b0, cfg_i.low_wait} +
                    {1'b0, (head_op_i.extra_wait ? cfg_i.clear_wait : 16'd0)};
  assign low_wait = low_sum[16] ? 16'hFFFF : low_sum[15:0];

  assign load  = !valid_q || out_ready_i;
  assign pop_o = load && !empty_i && phase_q;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    out_d   = out_q;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        phase_d      = !phase_q;
        out_d.rs     = head_op_i.rs;
        if (!phase_q) begin
          out_d.nibble     = head_op_i.value[7:4];
          out_d.pre_wait   = head_op_i.pre_wait ? cfg_i.power_wait : 16'd0;
          out_d.wait_after = cfg_i.high_wait;
          out_d.last       = 1'b0;
        end else begin
          out_d.nibble     = head_op_i.value[3:0];
          out_d.pre_wait   = 16'd0;
          out_d.wait_after = low_wait;
          out_d.last       = head_op_i.last;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/char_lcd_4bit_writer_core.sv -----
// Character LCD 4-bit writer.
// The slave stream takes one request per transfer: tuser holds the kind,
// tdata the byte, row and column. Each request becomes two to ten nibble
// transfers on the master stream, one per enable pulse, with the register
// select in tuser and tlast on the final transfer of the request.
// Kinds five to seven are taken and dropped.
// A front stage expands the request into bytes and writes them to a
// four-entry queue; the back stage splits each byte into its high and low
// nibble and adds the waits from the configuration registers.
// A request passes the front registers, the queue and the output register
// before its first transfer shows. Throughput: one nibble transfer per cycle
// while the receiver is ready, set by the output register.
// Multi-byte requests hold the slave side until their last byte is queued.
// Configuration writes are always taken; index four and up are ignored.
// Reset clears the queue and output and loads the default waits.
// When the receiver stalls, the output holds and the queue fills; the
// slave side then stalls once the queue is full.
module char_lcd_4bit_writer_core
  import clcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // byte_value[7:0], row[10:8], column[18:11]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // nibble[3:0], pre_wait_us[19:4],
                                     // wait_after_us[35:20]
  output logic        m_axis_tuser,  // rs[0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  push;
  op_t   push_op;
  logic  full;
  logic  pop;
  op_t   head_op;
  logic  empty;
  xfer_t xfer;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_wait  <= HIGH_WAIT_RST;
      cfg_q.low_wait   <= LOW_WAIT_RST;
      cfg_q.power_wait <= POWER_WAIT_RST;
      cfg_q.clear_wait <= CLEAR_WAIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HIGH_WAIT:  cfg_q.high_wait  <= cfg_data_i;
        CFG_LOW_WAIT:   cfg_q.low_wait   <= cfg_data_i;
        CFG_POWER_WAIT: cfg_q.power_wait <= cfg_data_i;
        CFG_CLEAR_WAIT: cfg_q.clear_wait <= cfg_data_i;
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  clcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_kind_i   (s_axis_tuser),
    .req_byte_i   (s_axis_tdata[7:0]),
    .req_row_i    (s_axis_tdata[10:8]),
    .req_column_i (s_axis_tdata[18:11]),
    .push_o       (push),
    .push_op_o    (push_op),
    .full_i       (full)
  );

  clcd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .head_op_o (head_op),
    .empty_o   (empty)
  );

  clcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_op_i   (head_op),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (xfer)
  );

  assign m_axis_tdata = {4'b0000, xfer.wait_after, xfer.pre_wait, xfer.nibble};
  assign m_axis_tuser = xfer.rs;
  assign m_axis_tlast = xfer.last;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty))
    else $error("queue read while empty");

  a_data_no_pre_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[19:4] == 16'd0))
    else $error("data transfer carries a pre-wait");

  a_last_is_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_op.last) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("final byte popped without a final transfer");
`endif

endmodule

// ----- tb/lcd_xfer_checker.sv -----
`timescale 1ns / 1ps
module lcd_xfer_checker
  import clcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [23:0] s_data_i,   // byte_value[7:0], row[10:8], column[18:11]
  input  logic [2:0]  s_user_i,   // kind[2:0]
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,   // nibble[3:0], pre_wait_us[19:4],
                                  // wait_after_us[35:20]
  input  logic        m_user_i,   // rs[0]
  input  logic        m_last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int unsigned MAX_PRINTED = 30;
  localparam logic [2:0]  ROW_FIRST   = 3'd1;
  localparam logic [2:0]  ROW_LAST    = 3'd4;
  localparam int unsigned INIT_CMDS   = 5;
  localparam logic [7:0]  CLEAR_CMD   = 8'h01;
  // row 4 down to row 1, one byte each
  localparam logic [31:0] ROW_BASES   = {8'hD4, 8'h94, 8'hC0, 8'h80};
  // last init command down to the first, one byte each
  localparam logic [39:0] INIT_CMD_SEQ = {8'h06, 8'h0C, 8'h01, 8'h28, 8'h02};

  cfg_t  waits;
  xfer_t due_xfers[$];
  xfer_t want;
  xfer_t got;

  function automatic logic [15:0] sat_sum(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  task automatic queue_byte(input logic rs, input logic [7:0] value,
                            input logic [15:0] pre, input logic [15:0] extra);
    xfer_t hi;
    xfer_t lo;
    hi.rs         = rs;
    hi.nibble     = value[7:4];
    hi.pre_wait   = pre;
    hi.wait_after = waits.high_wait;
    hi.last       = 1'b0;
    lo.rs         = rs;
    lo.nibble     = value[3:0];
    lo.pre_wait   = 16'd0;
    lo.wait_after = sat_sum(waits.low_wait, extra);
    lo.last       = 1'b0;
    due_xfers.push_back(hi);
    due_xfers.push_back(lo);
  endtask

  task automatic expand_request(input logic [2:0] kind, input logic [7:0] value,
                                input logic [2:0] row, input logic [7:0] column);
    int unsigned depth;
    int unsigned sel;
    int unsigned step;
    xfer_t       tail;
    depth = due_xfers.size();
    case (kind)
      KIND_CMD:  queue_byte(1'b0, value, 16'd0, 16'd0);
      KIND_DATA: queue_byte(1'b1, value, 16'd0, 16'd0);
      KIND_POS: begin
        if (row >= ROW_FIRST && row <= ROW_LAST) begin
          sel = row - ROW_FIRST;
          queue_byte(1'b0, ROW_BASES[8*sel +: 8] | {4'h0, column[3:0]}, 16'd0, 16'd0);
        end
        queue_byte(1'b1, value, 16'd0, 16'd0);
      end
      KIND_INIT: begin
        for (step = 0; step < INIT_CMDS; step++) begin
          queue_byte(1'b0, INIT_CMD_SEQ[8*step +: 8],
                     (step == 0) ? waits.power_wait : 16'd0, 16'd0);
        end
      end
      KIND_CLEAR: queue_byte(1'b0, CLEAR_CMD, 16'd0, waits.clear_wait);
      default: ;
    endcase
    if (due_xfers.size() > depth) begin
      tail      = due_xfers.pop_back();
      tail.last = 1'b1;
      due_xfers.push_back(tail);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] seen,
                                 input logic [15:0] wanted);
    fail_count_o++;
    if (fail_count_o <= MAX_PRINTED) begin
      $display("checker: %s at transfer %0d: got 0x%0h, expected 0x%0h",
               what, checked_o, seen, wanted);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      due_xfers.delete();
      waits.high_wait  = HIGH_WAIT_RST;
      waits.low_wait   = LOW_WAIT_RST;
      waits.power_wait = POWER_WAIT_RST;
      waits.clear_wait = CLEAR_WAIT_RST;
      fail_count_o     = 0;
      checked_o        = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_HIGH_WAIT:  waits.high_wait  = cfg_data_i;
          CFG_LOW_WAIT:   waits.low_wait   = cfg_data_i;
          CFG_POWER_WAIT: waits.power_wait = cfg_data_i;
          CFG_CLEAR_WAIT: waits.clear_wait = cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        expand_request(s_user_i, s_data_i[7:0], s_data_i[10:8], s_data_i[18:11]);
      end
      if (m_valid_i && m_ready_i) begin
        got.rs         = m_user_i;
        got.nibble     = m_data_i[3:0];
        got.pre_wait   = m_data_i[19:4];
        got.wait_after = m_data_i[35:20];
        got.last       = m_last_i;
        if (due_xfers.size() == 0) begin
          report_mismatch("transfer with none expected", {12'h0, got.nibble}, 16'h0);
        end else begin
          want = due_xfers.pop_front();
          if (got.rs != want.rs) begin
            report_mismatch("rs", {15'd0, got.rs}, {15'd0, want.rs});
          end
          if (got.nibble != want.nibble) begin
            report_mismatch("nibble", {12'd0, got.nibble}, {12'd0, want.nibble});
          end
          if (got.pre_wait != want.pre_wait) begin
            report_mismatch("pre_wait_us", got.pre_wait, want.pre_wait);
          end
          if (got.wait_after != want.wait_after) begin
            report_mismatch("wait_after_us", got.wait_after, want.wait_after);
          end
          if (got.last != want.last) begin
            report_mismatch("tlast", {15'd0, got.last}, {15'd0, want.last});
          end
        end
        checked_o++;
      end
    end
    pending_o = due_xfers.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import clcd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned PHASE_ITEMS      = 58;
  localparam int unsigned NUM_PHASES       = 6;
  localparam logic [2:0]  KIND_SPARE       = 3'(KIND_CLEAR) + 3'd1;
  localparam logic [2:0]  CFG_SPARE        = CFG_CLEAR_WAIT + 3'd1;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  int          fail_count;
  int          pending;
  int          checked;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  int unsigned req_count   = 0;
  int unsigned spare_count = 0;
  bit          gaps_on     = 1'b1;
  bit          long_hold_req  = 1'b0;
  bit          long_hold_done = 1'b0;

  char_lcd_4bit_writer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  lcd_xfer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_user_i     (m_axis_tuser),
    .m_last_i     (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // end the run if nothing moves on any channel for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: a series of random stall patterns, plus one long hold
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode_left = 0;
    mode      = 0;
    forever begin
      if (long_hold_req && !long_hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((mode_left % 8) < 3);
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_request(input logic [2:0] kind, input logic [7:0] value,
                              input logic [2:0] row, input logic [7:0] column);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 20);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, column, row, value};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    req_count++;
    if (kind >= KIND_SPARE) spare_count++;
  endtask

  task automatic send_random(output bit counted);
    int unsigned pick;
    logic [2:0]  kind;
    logic [2:0]  row;
    pick = $urandom_range(0, 99);
    if (pick < 25)      kind = KIND_CMD;
    else if (pick < 50) kind = KIND_DATA;
    else if (pick < 75) kind = KIND_POS;
    else if (pick < 83) kind = KIND_INIT;
    else if (pick < 93) kind = KIND_CLEAR;
    else                kind = KIND_SPARE + 3'($urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) row = 3'($urandom_range(0, 7));
    else                           row = 3'($urandom_range(1, 4));
    send_request(kind, 8'($urandom_range(0, 255)), row, 8'($urandom_range(0, 255)));
    counted = (kind < KIND_SPARE);
  endtask

  // stop offering and wait until every predicted transfer has arrived
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_waits(input logic [15:0] high, input logic [15:0] low,
                             input logic [15:0] power, input logic [15:0] clear,
                             input bit touch_spare);
    write_reg(CFG_HIGH_WAIT, high);
    write_reg(CFG_LOW_WAIT, low);
    write_reg(CFG_POWER_WAIT, power);
    write_reg(CFG_CLEAR_WAIT, clear);
    if (touch_spare) begin
      write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
      write_reg(CFG_SPARE + 3'd3, 16'($urandom_range(0, 65535)));
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned served;
    int unsigned split;
    bit          counted;
    bit          paused;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests at the reset waits
    send_request(KIND_CMD,   8'h00, 3'd0, 8'h00);
    send_request(KIND_CMD,   8'hFF, 3'd7, 8'hFF);
    send_request(KIND_DATA,  8'h00, 3'd0, 8'h00);
    send_request(KIND_DATA,  8'hFF, 3'd7, 8'hFF);
    send_request(KIND_DATA,  8'h5A, 3'd2, 8'hA5);
    send_request(KIND_POS,   8'h41, 3'd1, 8'h00);
    send_request(KIND_POS,   8'hFF, 3'd2, 8'hFF);
    send_request(KIND_POS,   8'h7E, 3'd3, 8'hF0);
    send_request(KIND_POS,   8'h00, 3'd4, 8'h0F);
    send_request(KIND_POS,   8'h30, 3'd0, 8'hAA);
    send_request(KIND_POS,   8'h31, 3'd5, 8'h03);
    send_request(KIND_POS,   8'h32, 3'd6, 8'h0C);
    send_request(KIND_POS,   8'h80, 3'd7, 8'h55);
    send_request(KIND_INIT,  8'hFF, 3'd7, 8'hFF);
    send_request(KIND_CLEAR, 8'hFF, 3'd7, 8'hFF);
    send_request(KIND_SPARE,        8'hFF, 3'd7, 8'hFF);
    send_request(KIND_SPARE + 3'd1, 8'h00, 3'd0, 8'h00);
    send_request(KIND_SPARE + 3'd2, 8'hA5, 3'd3, 8'h5A);
    send_request(KIND_CLEAR, 8'h00, 3'd0, 8'h00);
    send_request(KIND_INIT,  8'h00, 3'd0, 8'h00);
    drain_results();

    paused = 1'b0;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_waits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        1: write_waits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        2: write_waits(16'($urandom_range(0, 65535)), 16'hFFFF,
                       16'($urandom_range(0, 65535)), 16'h0001, 1'b0);
        3: begin
          // low plus clear lands exactly on the saturation point
          split = $urandom_range(0, 65535);
          write_waits(16'hFFFF, 16'(split), 16'h0000, 16'(65535 - split), 1'b1);
        end
        default: write_waits(16'($urandom_range(0, 65535)), 16'($urandom_range(32768, 65535)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             1'b0);
      endcase
      served = 0;
      while (served < PHASE_ITEMS) begin
        send_random(counted);
        if (counted) served++;
        if (phase == 1 && served == 30 && !paused) begin
          paused = 1'b1;
          drain_results();
        end
        // back-to-back offers against a long receiver hold to fill the block
        if (phase == 2 && served == 20 && !long_hold_req) begin
          gaps_on       = 1'b0;
          long_hold_req = 1'b1;
        end
        if (long_hold_done && !gaps_on) gaps_on = 1'b1;
      end
      drain_results();
    end

    $display("Run covered %0d requests (%0d of unused kinds), %0d nibble transfers checked,",
             req_count, spare_count, checked);
    $display("at reset waits and %0d wait settings incl. zero, full-scale and saturating sums.",
             NUM_PHASES);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
